// ===== rtl/eight_bit_alu_with_flags_macros.svh =====
// Assertion helpers used by the top-level RTL file of the ALU.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EBALU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ALU check failed");

// The consequent must hold in the cycle after the antecedent.
`define EBALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ALU check failed");

`endif

// ===== rtl/ebalu_pkg.sv =====
package ebalu_pkg;

  // Operation codes carried on the input tuser bus.
  typedef enum logic [4:0] {
    K_ADD    = 5'd0,
    K_ADC    = 5'd1,
    K_SUB    = 5'd2,
    K_SBC    = 5'd3,
    K_AND    = 5'd4,
    K_XOR    = 5'd5,
    K_OR     = 5'd6,
    K_CP     = 5'd7,
    K_INC    = 5'd8,
    K_DEC    = 5'd9,
    K_RLC    = 5'd10,
    K_RRC    = 5'd11,
    K_RL     = 5'd12,
    K_RR     = 5'd13,
    K_SLA    = 5'd14,
    K_SRA    = 5'd15,
    K_SWAP   = 5'd16,
    K_SRL    = 5'd17,
    K_BIT    = 5'd18,
    K_RES    = 5'd19,
    K_SET    = 5'd20,
    K_DAA    = 5'd21,
    K_CPL    = 5'd22,
    K_SCF    = 5'd23,
    K_CCF    = 5'd24,
    K_RLCA   = 5'd25,
    K_RRCA   = 5'd26,
    K_RLA    = 5'd27,
    K_RRA    = 5'd28,
    K_ADD16L = 5'd29,
    K_ADD16H = 5'd30,
    K_SPADD  = 5'd31
  } kind_e;

  // Flag bit positions.
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  // One operation request.
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  flags_in;
    logic [2:0]  bit_index;
    logic [15:0] wide_lhs;
    logic [7:0]  rhs;
    logic [7:0]  lhs;
  } req_t;

  // One operation result.
  typedef struct packed {
    logic [3:0]  flags_out;
    logic [15:0] wide_result;
    logic [7:0]  result;
  } rsp_t;

endpackage

// ===== rtl/ebalu_core.sv =====
module ebalu_core (
  input  ebalu_pkg::req_t req_i,
  output ebalu_pkg::rsp_t rsp_o
);

  // Rotate and shift group: returns {carry, byte}.
  // sel: rlc, rrc, rl, rr, sla, sra, swap, srl.
  function automatic logic [8:0] shift_op(input logic [2:0] sel, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] o;
    case (sel)
      3'd0:    o = {v[7], v[6:0], v[7]};
      3'd1:    o = {v[0], v[0], v[7:1]};
      3'd2:    o = {v[7], v[6:0], cin};
      3'd3:    o = {v[0], cin, v[7:1]};
      3'd4:    o = {v[7], v[6:0], 1'b0};
      3'd5:    o = {v[0], v[7], v[7:1]};
      3'd6:    o = {1'b0, v[3:0], v[7:4]};
      default: o = {v[0], 1'b0, v[7:1]};
    endcase
    return o;
  endfunction

  logic [7:0]  a, b;
  logic        cin;
  logic        carry_use;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [8:0]  sh_cb, sh_acc;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_v;
  logic        daa_c;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;
  logic [7:0]  res;
  logic [15:0] wres;
  logic [3:0]  fo;

  assign a   = req_i.lhs;
  assign b   = req_i.rhs;
  assign cin = req_i.flags_in[ebalu_pkg::FlagC];

  // Carry in only for the with-carry forms.
  assign carry_use = cin & ((req_i.kind == ebalu_pkg::K_ADC) ||
                            (req_i.kind == ebalu_pkg::K_SBC) ||
                            (req_i.kind == ebalu_pkg::K_ADD16H));

  // Shared adder and subtractor with nibble carries.
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, carry_use};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_use};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, carry_use};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_use};

  // Kind 10..17 maps to select 0..7 by its low bits minus two; 25..28 minus one.
  assign sh_cb  = shift_op(req_i.kind[2:0] - 3'd2, a, cin);
  assign sh_acc = shift_op(req_i.kind[2:0] - 3'd1, a, cin);

  assign bit_mask = 8'd1 << req_i.bit_index;

  // Decimal adjust after add or subtract.
  always_comb begin
    daa_v = a;
    daa_c = cin;
    if (req_i.flags_in[ebalu_pkg::FlagN]) begin
      if (cin) begin
        daa_v = daa_v - 8'h60;
      end
      if (req_i.flags_in[ebalu_pkg::FlagH]) begin
        daa_v = daa_v - 8'h06;
      end
    end else begin
      if (cin || (a > 8'h99)) begin
        daa_v = daa_v + 8'h60;
        daa_c = 1'b1;
      end
      if (req_i.flags_in[ebalu_pkg::FlagH] || (a[3:0] > 4'h9)) begin
        daa_v = daa_v + 8'h06;
      end
    end
  end

  // Stack pointer plus sign-extended offset; flags from the low byte.
  assign sp_sum  = req_i.wide_lhs + {{8{b[7]}}, b};
  assign sp_half = {1'b0, req_i.wide_lhs[3:0]} + {1'b0, b[3:0]};
  assign sp_low  = {1'b0, req_i.wide_lhs[7:0]} + {1'b0, b};

  // Result and flag selection.
  always_comb begin
    res  = a;
    wres = 16'd0;
    fo   = req_i.flags_in;
    case (req_i.kind)
      ebalu_pkg::K_ADD, ebalu_pkg::K_ADC: begin
        res = add_sum[7:0];
        fo  = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
      end
      ebalu_pkg::K_SUB, ebalu_pkg::K_SBC: begin
        res = sub_diff[7:0];
        fo  = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
      end
      ebalu_pkg::K_CP: begin
        fo = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
      end
      ebalu_pkg::K_AND: begin
        res = a & b;
        fo  = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ebalu_pkg::K_XOR: begin
        res = a ^ b;
        fo  = {(a ^ b) == 8'd0, 3'b000};
      end
      ebalu_pkg::K_OR: begin
        res = a | b;
        fo  = {(a | b) == 8'd0, 3'b000};
      end
      ebalu_pkg::K_INC: begin
        res = a + 8'd1;
        fo  = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, cin};
      end
      ebalu_pkg::K_DEC: begin
        res = a - 8'd1;
        fo  = {a == 8'h01, 1'b1, a[3:0] == 4'h0, cin};
      end
      ebalu_pkg::K_RLC, ebalu_pkg::K_RRC, ebalu_pkg::K_RL, ebalu_pkg::K_RR,
      ebalu_pkg::K_SLA, ebalu_pkg::K_SRA, ebalu_pkg::K_SWAP, ebalu_pkg::K_SRL: begin
        res = sh_cb[7:0];
        fo  = {sh_cb[7:0] == 8'd0, 2'b00, sh_cb[8]};
      end
      ebalu_pkg::K_BIT: begin
        fo = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
      end
      ebalu_pkg::K_RES: begin
        res = a & ~bit_mask;
      end
      ebalu_pkg::K_SET: begin
        res = a | bit_mask;
      end
      ebalu_pkg::K_DAA: begin
        res = daa_v;
        fo  = {daa_v == 8'd0, req_i.flags_in[ebalu_pkg::FlagN], 1'b0, daa_c};
      end
      ebalu_pkg::K_CPL: begin
        res = ~a;
        fo  = req_i.flags_in | 4'b0110;
      end
      ebalu_pkg::K_SCF: begin
        fo = {req_i.flags_in[ebalu_pkg::FlagZ], 3'b001};
      end
      ebalu_pkg::K_CCF: begin
        fo = {req_i.flags_in[ebalu_pkg::FlagZ], 2'b00, ~cin};
      end
      ebalu_pkg::K_RLCA, ebalu_pkg::K_RRCA, ebalu_pkg::K_RLA, ebalu_pkg::K_RRA: begin
        res = sh_acc[7:0];
        fo  = {3'b000, sh_acc[8]};
      end
      ebalu_pkg::K_ADD16L, ebalu_pkg::K_ADD16H: begin
        res = add_sum[7:0];
        fo  = {req_i.flags_in[ebalu_pkg::FlagZ], 1'b0, add_half[4], add_sum[8]};
      end
      ebalu_pkg::K_SPADD: begin
        wres = sp_sum;
        res  = sp_sum[7:0];
        fo   = {2'b00, sp_half[4], sp_low[8]};
      end
      default: begin
        res = a;
      end
    endcase
  end

  assign rsp_o.result      = res;
  assign rsp_o.wide_result = wres;
  assign rsp_o.flags_out   = fo;

endmodule

// ===== rtl/eight_bit_alu_with_flags.sv =====
// Eight-bit CPU ALU with Z/N/H/C flags. Each request carries an operation code
// on s_axis_tuser_i and its operands on s_axis_tdata_i; each request yields
// exactly one response on the master side, in order. A request is registered,
// evaluated by one pass of combinational logic and registered again. Its
// response is valid on the master side once it has moved from the input
// register into the output register, which it does as soon as that has room.
// One request is taken every cycle as long as the response side keeps up.
// The two register stages hold at most two requests while the response side
// stalls, and input ready follows output ready in the same cycle.
`include "eight_bit_alu_with_flags_macros.svh"

module eight_bit_alu_with_flags (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // lhs[7:0], rhs[15:8], wide_lhs[31:16], bit_index[34:32], flags_in[38:35], zero[39]
  input  logic [ebalu_pkg::InDataW-1:0]   s_axis_tdata_i,
  // kind[4:0]
  input  logic [4:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // result[7:0], wide_result[23:8], flags_out[27:24], zero[31:28]
  output logic [ebalu_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  logic             in_valid_q, in_valid_d;
  ebalu_pkg::req_t  in_req_q, in_req_d;
  logic             out_valid_q, out_valid_d;
  ebalu_pkg::rsp_t  out_rsp_q;
  ebalu_pkg::rsp_t  core_rsp;
  logic             out_ready;
  logic             in_ready;

  // Each stage can take new data when empty or when its content moves on.
  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign in_ready  = !in_valid_q || out_ready;
  assign s_axis_tready_o = in_ready;

  // Unpack the incoming request.
  always_comb begin
    in_req_d.kind      = ebalu_pkg::kind_e'(s_axis_tuser_i);
    in_req_d.lhs       = s_axis_tdata_i[7:0];
    in_req_d.rhs       = s_axis_tdata_i[15:8];
    in_req_d.wide_lhs  = s_axis_tdata_i[31:16];
    in_req_d.bit_index = s_axis_tdata_i[34:32];
    in_req_d.flags_in  = s_axis_tdata_i[38:35];
  end

  assign in_valid_d  = in_ready ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;

  // Valid bits of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_req_q <= in_req_d;
    end
    if (out_ready && in_valid_q) begin
      out_rsp_q <= core_rsp;
    end
  end

  ebalu_core u_core (
    .req_i (in_req_q),
    .rsp_o (core_rsp)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_rsp_q.flags_out, out_rsp_q.wide_result,
                            out_rsp_q.result};

  // A request in the first stage moves into the output stage when it has room.
  `EBALU_ASSERT_NEXT(a_stage_advance, in_valid_q && out_ready, out_valid_q)
  // The registered response is the one computed from the first stage.
  `EBALU_ASSERT_NEXT(a_rsp_capture, in_valid_q && out_ready, out_rsp_q == $past(core_rsp))
  // Back-pressure only when both stages are full and the sink stalls.
  `EBALU_ASSERT_SAME(a_ready_low, !s_axis_tready_o,
                     in_valid_q && out_valid_q && !m_axis_tready_i)
  // Only the stack pointer operation produces a wide result.
  `EBALU_ASSERT_SAME(a_wide_zero, in_valid_q && (in_req_q.kind != ebalu_pkg::K_SPADD),
                     core_rsp.wide_result == 16'd0)
  // Subtract, compare and decrement always set N.
  `EBALU_ASSERT_SAME(a_sub_sets_n,
                     in_valid_q && ((in_req_q.kind == ebalu_pkg::K_SUB) ||
                                    (in_req_q.kind == ebalu_pkg::K_SBC) ||
                                    (in_req_q.kind == ebalu_pkg::K_CP) ||
                                    (in_req_q.kind == ebalu_pkg::K_DEC)),
                     core_rsp.flags_out[ebalu_pkg::FlagN])

endmodule

// ===== tb/eight_bit_alu_with_flags_tb.sv =====
module eight_bit_alu_with_flags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned DrainCycles = 8;

  // One operation request as the testbench sees it.
  typedef struct {
    ebalu_pkg::kind_e kind;
    logic [7:0]       lhs;
    logic [7:0]       rhs;
    logic [15:0]      wide_lhs;
    logic [2:0]       bit_index;
    logic [3:0]       flags_in;
  } alu_req_t;

  // One operation result.
  typedef struct {
    logic [7:0]  result;
    logic [15:0] wide_result;
    logic [3:0]  flags;
  } alu_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // lhs[7:0], rhs[15:8], wide_lhs[31:16], bit_index[34:32], flags_in[38:35], zero[39]
  logic [ebalu_pkg::InDataW-1:0] s_axis_tdata_i = '0;
  // kind[4:0]
  logic [4:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // result[7:0], wide_result[23:8], flags_out[27:24], zero[31:28]
  logic [ebalu_pkg::OutDataW-1:0] m_axis_tdata_o;

  alu_rsp_t    expected_rsp_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned rx_hold_cycles = 0;
  alu_rsp_t    got_rsp;
  alu_rsp_t    want_rsp;

  eight_bit_alu_with_flags DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Free-running clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Computes the ALU outcome of one request.
  function automatic alu_rsp_t alu_predict(alu_req_t rq);
    alu_rsp_t         r;
    logic             cin;
    logic             cy;
    logic [8:0]       sum9;
    logic [4:0]       nib;
    logic [7:0]       mask;
    logic [7:0]       v;
    ebalu_pkg::kind_e op;
    cin           = rq.flags_in[ebalu_pkg::FlagC];
    mask          = 8'h01 << rq.bit_index;
    r.result      = rq.lhs;
    r.wide_result = '0;
    r.flags       = rq.flags_in;
    case (rq.kind)
      ebalu_pkg::K_ADD, ebalu_pkg::K_ADC, ebalu_pkg::K_ADD16L, ebalu_pkg::K_ADD16H: begin
        cy = (rq.kind == ebalu_pkg::K_ADC || rq.kind == ebalu_pkg::K_ADD16H) ? cin : 1'b0;
        sum9 = {1'b0, rq.lhs} + {1'b0, rq.rhs} + cy;
        nib = {1'b0, rq.lhs[3:0]} + {1'b0, rq.rhs[3:0]} + cy;
        r.result = sum9[7:0];
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = (sum9[7:0] == 8'h00);
        r.flags[ebalu_pkg::FlagH] = nib[4];
        r.flags[ebalu_pkg::FlagC] = sum9[8];
        // The two halves of a 16-bit add leave Z alone.
        if (rq.kind == ebalu_pkg::K_ADD16L || rq.kind == ebalu_pkg::K_ADD16H) begin
          r.flags[ebalu_pkg::FlagZ] = rq.flags_in[ebalu_pkg::FlagZ];
        end
      end
      ebalu_pkg::K_SUB, ebalu_pkg::K_SBC, ebalu_pkg::K_CP: begin
        cy = (rq.kind == ebalu_pkg::K_SBC) ? cin : 1'b0;
        // Bit 8 and bit 4 of the wide differences are the borrows.
        sum9 = {1'b0, rq.lhs} - {1'b0, rq.rhs} - cy;
        nib = {1'b0, rq.lhs[3:0]} - {1'b0, rq.rhs[3:0]} - cy;
        if (rq.kind != ebalu_pkg::K_CP) begin
          r.result = sum9[7:0];
        end
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = (sum9[7:0] == 8'h00);
        r.flags[ebalu_pkg::FlagN] = 1'b1;
        r.flags[ebalu_pkg::FlagH] = nib[4];
        r.flags[ebalu_pkg::FlagC] = sum9[8];
      end
      ebalu_pkg::K_AND, ebalu_pkg::K_XOR, ebalu_pkg::K_OR: begin
        if (rq.kind == ebalu_pkg::K_AND) begin
          r.result = rq.lhs & rq.rhs;
        end else if (rq.kind == ebalu_pkg::K_XOR) begin
          r.result = rq.lhs ^ rq.rhs;
        end else begin
          r.result = rq.lhs | rq.rhs;
        end
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = (r.result == 8'h00);
        r.flags[ebalu_pkg::FlagH] = (rq.kind == ebalu_pkg::K_AND);
      end
      ebalu_pkg::K_INC, ebalu_pkg::K_DEC: begin
        r.result = (rq.kind == ebalu_pkg::K_INC) ? rq.lhs + 8'd1 : rq.lhs - 8'd1;
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = (r.result == 8'h00);
        r.flags[ebalu_pkg::FlagN] = (rq.kind == ebalu_pkg::K_DEC);
        r.flags[ebalu_pkg::FlagH] = (rq.kind == ebalu_pkg::K_INC) ? (rq.lhs[3:0] == 4'hF)
                                                                   : (rq.lhs[3:0] == 4'h0);
        r.flags[ebalu_pkg::FlagC] = cin;
      end
      ebalu_pkg::K_RLC, ebalu_pkg::K_RRC, ebalu_pkg::K_RL, ebalu_pkg::K_RR,
      ebalu_pkg::K_SLA, ebalu_pkg::K_SRA, ebalu_pkg::K_SWAP, ebalu_pkg::K_SRL,
      ebalu_pkg::K_RLCA, ebalu_pkg::K_RRCA, ebalu_pkg::K_RLA, ebalu_pkg::K_RRA: begin
        // Accumulator rotates behave like their prefixed twins except for Z.
        op = (rq.kind >= ebalu_pkg::K_RLCA)
             ? ebalu_pkg::kind_e'(rq.kind - ebalu_pkg::K_RLCA + ebalu_pkg::K_RLC)
             : rq.kind;
        case (op)
          ebalu_pkg::K_RLC: begin
            v = {rq.lhs[6:0], rq.lhs[7]};
            cy = rq.lhs[7];
          end
          ebalu_pkg::K_RRC: begin
            v = {rq.lhs[0], rq.lhs[7:1]};
            cy = rq.lhs[0];
          end
          ebalu_pkg::K_RL: begin
            v = {rq.lhs[6:0], cin};
            cy = rq.lhs[7];
          end
          ebalu_pkg::K_RR: begin
            v = {cin, rq.lhs[7:1]};
            cy = rq.lhs[0];
          end
          ebalu_pkg::K_SLA: begin
            v = {rq.lhs[6:0], 1'b0};
            cy = rq.lhs[7];
          end
          ebalu_pkg::K_SRA: begin
            v = {rq.lhs[7], rq.lhs[7:1]};
            cy = rq.lhs[0];
          end
          ebalu_pkg::K_SWAP: begin
            v = {rq.lhs[3:0], rq.lhs[7:4]};
            cy = 1'b0;
          end
          default: begin
            v = {1'b0, rq.lhs[7:1]};
            cy = rq.lhs[0];
          end
        endcase
        r.result = v;
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = (rq.kind < ebalu_pkg::K_RLCA) && (v == 8'h00);
        r.flags[ebalu_pkg::FlagC] = cy;
      end
      ebalu_pkg::K_BIT: begin
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = ((rq.lhs & mask) == 8'h00);
        r.flags[ebalu_pkg::FlagH] = 1'b1;
        r.flags[ebalu_pkg::FlagC] = cin;
      end
      ebalu_pkg::K_RES: r.result = rq.lhs & ~mask;
      ebalu_pkg::K_SET: r.result = rq.lhs | mask;
      ebalu_pkg::K_DAA: begin
        v = rq.lhs;
        cy = cin;
        if (rq.flags_in[ebalu_pkg::FlagN]) begin
          if (cy) v = v - 8'h60;
          if (rq.flags_in[ebalu_pkg::FlagH]) v = v - 8'h06;
        end else begin
          // Adding 0x60 leaves the low nibble as it was.
          if (cy || v > 8'h99) begin
            v = v + 8'h60;
            cy = 1'b1;
          end
          if (rq.flags_in[ebalu_pkg::FlagH] || v[3:0] > 4'h9) v = v + 8'h06;
        end
        r.result = v;
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = (v == 8'h00);
        r.flags[ebalu_pkg::FlagN] = rq.flags_in[ebalu_pkg::FlagN];
        r.flags[ebalu_pkg::FlagC] = cy;
      end
      ebalu_pkg::K_CPL: begin
        r.result = ~rq.lhs;
        r.flags[ebalu_pkg::FlagN] = 1'b1;
        r.flags[ebalu_pkg::FlagH] = 1'b1;
      end
      ebalu_pkg::K_SCF, ebalu_pkg::K_CCF: begin
        r.flags = '0;
        r.flags[ebalu_pkg::FlagZ] = rq.flags_in[ebalu_pkg::FlagZ];
        r.flags[ebalu_pkg::FlagC] = (rq.kind == ebalu_pkg::K_SCF) ? 1'b1 : ~cin;
      end
      ebalu_pkg::K_SPADD: begin
        // Sign-extended offset; H and C come from the low byte only.
        r.wide_result = rq.wide_lhs + {{8{rq.rhs[7]}}, rq.rhs};
        r.result = r.wide_result[7:0];
        nib = {1'b0, rq.wide_lhs[3:0]} + {1'b0, rq.rhs[3:0]};
        sum9 = {1'b0, rq.wide_lhs[7:0]} + {1'b0, rq.rhs};
        r.flags = '0;
        r.flags[ebalu_pkg::FlagH] = nib[4];
        r.flags[ebalu_pkg::FlagC] = sum9[8];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Byte operand with extra weight on the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic alu_req_t random_request();
    alu_req_t rq;
    rq.kind      = ebalu_pkg::kind_e'($urandom_range(0, 31));
    rq.lhs       = pick_byte();
    rq.rhs       = pick_byte();
    rq.wide_lhs  = {pick_byte(), pick_byte()};
    rq.bit_index = 3'($urandom_range(0, 7));
    rq.flags_in  = 4'($urandom_range(0, 15));
    return rq;
  endfunction

  // Offers one request, waits for its acceptance and records the outcome.
  task automatic send_request(input alu_req_t rq);
    int unsigned gap;
    logic        taken;
    gap = tx_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, rq.flags_in, rq.bit_index, rq.wide_lhs, rq.rhs, rq.lhs};
    s_axis_tuser_i  <= rq.kind;
    // Ready is sampled mid-cycle, where it is stable up to the next edge.
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    expected_rsp_q.push_back(alu_predict(rq));
  endtask

  // Every operation once, with operands cycling through the extremes.
  task automatic test_each_operation();
    alu_req_t rq;
    for (int k = 0; k < 32; k++) begin
      rq.kind = ebalu_pkg::kind_e'(k);
      case (k % 4)
        0: begin
          rq.lhs = 8'hFF; rq.rhs = 8'h01; rq.wide_lhs = 16'hFFFF;
          rq.bit_index = 3'd7; rq.flags_in = 4'hF;
        end
        1: begin
          rq.lhs = 8'h00; rq.rhs = 8'h80; rq.wide_lhs = 16'h0000;
          rq.bit_index = 3'd0; rq.flags_in = 4'h0;
        end
        2: begin
          rq.lhs = 8'h9A; rq.rhs = 8'hFF; rq.wide_lhs = 16'h00FF;
          rq.bit_index = 3'd3; rq.flags_in = 4'b0001;
        end
        default: begin
          rq.lhs = 8'h0F; rq.rhs = 8'h7F; rq.wide_lhs = 16'h8000;
          rq.bit_index = 3'd4; rq.flags_in = 4'b0110;
        end
      endcase
      send_request(rq);
    end
  endtask

  // Random requests with random idling on both sides.
  task automatic test_random_traffic(input int unsigned count);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (count) send_request(random_request());
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_cycles = 40;
    repeat (30) send_request(random_request());
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (60) send_request(random_request());
  endtask

  // Response side: random stalls, plus a long hold when one is asked for.
  initial begin
    int unsigned wait_cycles;
    logic        hit;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      wait_cycles = rx_hold_cycles + (rx_idle_en ? $urandom_range(0, 3) : 0);
      rx_hold_cycles = 0;
      if (wait_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        hit = m_axis_tvalid_o;
        @(posedge clk_i);
      end while (!hit);
    end
  end

  // Checks each response against the oldest outstanding outcome.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_rsp.result      = m_axis_tdata_o[7:0];
      got_rsp.wide_result = m_axis_tdata_o[23:8];
      got_rsp.flags       = m_axis_tdata_o[27:24];
      if (expected_rsp_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported) begin
          $display("unexpected response: result %h wide %h flags %b",
                   got_rsp.result, got_rsp.wide_result, got_rsp.flags);
        end
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        if (got_rsp.result != want_rsp.result ||
            got_rsp.wide_result != want_rsp.wide_result ||
            got_rsp.flags != want_rsp.flags) begin
          error_count++;
          if (error_count <= MaxReported) begin
            $display("mismatch: result %h/%h wide %h/%h flags %b/%b (expected/actual)",
                     want_rsp.result, got_rsp.result, want_rsp.wide_result,
                     got_rsp.wide_result, want_rsp.flags, got_rsp.flags);
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_each_operation();
    test_random_traffic(150);
    test_backpressure();
    test_random_traffic(160);
    test_back_to_back();
    s_axis_tvalid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
